[rtl/core/cwt_pkg.sv]
// shared constants and helpers for the card whitelist table
package cwt_pkg;

    localparam int ENTRIES    = 256;
    localparam int CARD_BYTES = 4;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    localparam int REQ_W    = 3;
    localparam int CARD_W   = 32;
    localparam int ROOM_W   = 16;
    localparam int EIDX_W   = 8;
    localparam int STATUS_W = 2;
    localparam int RIDX_W   = 8;
    localparam int USED_W   = 9;

    localparam int IN_W  = 64;
    localparam int OUT_W = 24;

    localparam logic [REQ_W-1:0] REQ_LOOKUP   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ADD      = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DEL_CARD = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DEL_IDX  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [ROOM_W-1:0] room;
        logic [CARD_W-1:0] card;
    } entry_t;

    // first CARD_BYTES bytes of the card, most significant byte first
    function automatic logic [CARD_W-1:0] card_mask();
        logic [CARD_W-1:0] m;
        m = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (i < CARD_BYTES)
            begin
                m[CARD_W-1-8*i -: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    localparam logic [CARD_W-1:0] CARD_MASK = card_mask();

endpackage

[rtl/core/card_whitelist_table.sv]
// card whitelist table: unordered (room, card) store with scan, add and swap-remove
//
// input words on s_tvalid/s_tready/s_tdata carry one request each: lookup, add,
// delete by card, delete by index or clear. each request gives exactly one
// output word on m_tvalid/m_tready/m_tdata with status, index and entry count.
// entries live in one synchronous ram of ENTRIES words; a scan reads one slot
// per cycle and compares the registered read data the next cycle.
// lookup and add scan the entries from index 0 until a hit or the entry count;
// delete by index goes through a swap write only when the last entry is moved
// into the hole, and clear goes straight to the result. delete by card scans
// all entries and moves the last entry into each hole it removes, as every
// swap-with-last restarts the scan at the hole.
// one request is worked on at a time; a new request is taken as soon as the
// previous result sits in the output register, even while it is stalled.
// a result that finds the output register still full waits until m_tready.
// reset clears the entry count and the handshake state only; ram contents
// are not cleared and slots at or above the count are never used.
module card_whitelist_table
    import cwt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // req_type, card_id, room, entry_index
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // status, result_index, entries_used
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_SWAP_WR = 3'd2;
    localparam logic [2:0] S_DONE    = 3'd3;

    localparam int EXT_W = (CNT_W > EIDX_W) ? CNT_W : EIDX_W;

    logic [REQ_W-1:0]  in_req;
    logic [CARD_W-1:0] in_card;
    logic [ROOM_W-1:0] in_room;
    logic [EIDX_W-1:0] in_eidx;

    assign in_req  = s_tdata[2:0];
    assign in_card = s_tdata[34:3];
    assign in_room = s_tdata[50:35];
    assign in_eidx = s_tdata[58:51];

    logic [2:0]          state_reg, state_next;
    logic [REQ_W-1:0]    req_reg, req_next;
    logic [CARD_W-1:0]   card_reg, card_next;
    logic [ROOM_W-1:0]   room_reg, room_next;
    logic [IDX_W-1:0]    hole_reg, hole_next;
    logic [CNT_W-1:0]    scan_idx_reg, scan_idx_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                hit_reg, hit_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [RIDX_W-1:0]   res_idx_reg, res_idx_next;
    logic                out_vld_reg, out_vld_next;
    logic [OUT_W-1:0]    out_data_reg, out_data_next;

    entry_t            mem [ENTRIES];
    entry_t            mem_rdata_reg;
    logic [IDX_W-1:0]  mem_raddr;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    entry_t            mem_wdata;

    logic              accept;
    logic              card_hit;
    logic              match;
    logic [IDX_W-1:0]  last_idx;
    logic [EXT_W-1:0]  eidx_ext;
    logic [EXT_W-1:0]  count_ext;

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = out_data_reg;

    assign last_idx  = IDX_W'(count_reg - CNT_W'(1));
    assign eidx_ext  = EXT_W'(in_eidx);
    assign count_ext = EXT_W'(count_reg);

    assign card_hit = ((mem_rdata_reg.card & CARD_MASK) == (card_reg & CARD_MASK));
    assign match    = cmp_vld_reg && card_hit &&
                      ((req_reg != REQ_ADD) || (mem_rdata_reg.room == room_reg));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        card_next       = card_reg;
        room_next       = room_reg;
        hole_next       = hole_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        count_next      = count_reg;
        hit_next        = hit_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        out_vld_next    = out_vld_reg && !m_tready;
        out_data_next   = out_data_reg;
        mem_raddr       = scan_idx_reg[IDX_W-1:0];
        mem_we          = 1'b0;
        mem_waddr       = count_reg[IDX_W-1:0];
        mem_wdata       = '{room: room_reg, card: card_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next        = in_req;
                    card_next       = in_card;
                    room_next       = in_room;
                    res_idx_next    = '0;
                    res_status_next = ST_MISS;
                    hit_next        = 1'b0;
                    scan_idx_next   = '0;
                    state_next      = S_DONE;
                    case (in_req)
                        REQ_LOOKUP, REQ_ADD, REQ_DEL_CARD:
                        begin
                            state_next = S_SCAN;
                        end
                        REQ_DEL_IDX:
                        begin
                            if (eidx_ext < count_ext)
                            begin
                                count_next      = count_reg - CNT_W'(1);
                                res_status_next = ST_OK;
                                res_idx_next    = in_eidx;
                                if (eidx_ext != EXT_W'(count_reg - CNT_W'(1)))
                                begin
                                    mem_raddr  = last_idx;
                                    hole_next  = IDX_W'(in_eidx);
                                    state_next = S_SWAP_WR;
                                end
                            end
                        end
                        REQ_CLEAR:
                        begin
                            count_next      = '0;
                            res_status_next = ST_OK;
                        end
                        default:
                        begin
                            res_status_next = ST_MISS;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (match)
                begin
                    if (req_reg == REQ_DEL_CARD)
                    begin
                        hit_next      = 1'b1;
                        count_next    = count_reg - CNT_W'(1);
                        scan_idx_next = CNT_W'(cmp_idx_reg);
                        if (cmp_idx_reg != last_idx)
                        begin
                            mem_raddr  = last_idx;
                            hole_next  = cmp_idx_reg;
                            state_next = S_SWAP_WR;
                        end
                    end
                    else
                    begin
                        res_status_next = ST_OK;
                        res_idx_next    = RIDX_W'(cmp_idx_reg);
                        state_next      = S_DONE;
                    end
                end
                else if (scan_idx_reg < count_reg)
                begin
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = S_DONE;
                    case (req_reg)
                        REQ_ADD:
                        begin
                            if (count_reg < CNT_W'(ENTRIES))
                            begin
                                mem_we          = 1'b1;
                                count_next      = count_reg + CNT_W'(1);
                                res_status_next = ST_OK;
                                res_idx_next    = RIDX_W'(count_reg);
                            end
                            else
                            begin
                                res_status_next = ST_FULL;
                            end
                        end
                        REQ_DEL_CARD:
                        begin
                            res_status_next = hit_reg ? ST_OK : ST_MISS;
                        end
                        default:
                        begin
                            res_status_next = ST_MISS;
                        end
                    endcase
                end
            end

            S_SWAP_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = hole_reg;
                mem_wdata = mem_rdata_reg;
                if (req_reg == REQ_DEL_CARD)
                begin
                    scan_idx_next = CNT_W'(hole_reg);
                    state_next    = S_SCAN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_vld_reg || m_tready)
                begin
                    out_vld_next  = 1'b1;
                    out_data_next = {5'b0, USED_W'(count_reg), res_idx_reg, res_status_reg};
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            cmp_vld_reg  <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            cmp_vld_reg  <= cmp_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        card_reg       <= card_next;
        room_reg       <= room_next;
        hole_reg       <= hole_next;
        scan_idx_reg   <= scan_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        hit_reg        <= hit_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        out_data_reg   <= out_data_next;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("entry count above table size");

    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_SWAP_WR) ||
                   ((state_reg == S_SCAN) && (req_reg == REQ_ADD)))
        else $error("ram write outside add or swap");

    a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_req == REQ_CLEAR)) |=> (count_reg == '0))
        else $error("clear left entries");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_idx_reg <= count_reg))
        else $error("scan pointer past entry count");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        (state_next == S_DONE && state_reg != S_DONE) |=>
            (res_status_reg == ST_OK || res_status_reg == ST_MISS ||
             res_status_reg == ST_FULL))
        else $error("bad status code");

endmodule
